// ===== sv/rpcp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the rotate, project and clip point pipeline.
package rpcp_pkg;

    localparam int POINT_W    = 16;
    localparam int COEF_W     = 18;
    localparam int ROW_W      = 3 * COEF_W;
    localparam int PROD_W     = COEF_W + POINT_W;
    localparam int ROT_W      = PROD_W + 2;
    localparam int ZOOM_W     = 16;
    localparam int PAN_W      = 16;
    localparam int SCALED_W   = ROT_W + ZOOM_W + 1;
    localparam int FRAC_SHIFT = 34;
    localparam int ACC_W      = SCALED_W + 1;
    localparam int PIX_W      = 16;
    localparam int CFG_IDX_W  = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Identity matrix, one Q2.16 coefficient of 1.0 per row
    localparam logic [ROW_W-1:0] ROW0_RESET = ROW_W'(64'd65536);
    localparam logic [ROW_W-1:0] ROW1_RESET = ROW_W'(64'd17179869184);
    localparam logic [ROW_W-1:0] ROW2_RESET = ROW_W'(64'd4503599627370496);
    localparam logic [ZOOM_W-1:0] ZOOM_RESET = ZOOM_W'(16);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATRIX_ROW0 = 3'd0,
        REG_MATRIX_ROW1 = 3'd1,
        REG_MATRIX_ROW2 = 3'd2,
        REG_ZOOM_SCALE  = 3'd3,
        REG_PAN_X       = 3'd4,
        REG_PAN_Y       = 3'd5,
        REG_SHOW_HIDDEN = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_BREAK = 2'd1,
        KIND_NONE  = 2'd2
    } point_kind_t;

    // One rotated and classified point travelling from front to back
    typedef struct packed {
        logic signed [ROT_W-1:0] rx;
        logic signed [ROT_W-1:0] ry;
        logic                    proj;
        logic                    zero;
        logic                    eol;
    } rot_item_t;

    typedef struct packed {
        logic [ZOOM_W-1:0]        zoom;
        logic signed [PAN_W-1:0]  pan_x;
        logic signed [PAN_W-1:0]  pan_y;
    } proj_cfg_t;

endpackage

// ===== sv/rpcp_front.sv =====
`timescale 1ns / 1ps
// Front end: accept points, rotate by the matrix and classify by depth.
module rpcp_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [rpcp_pkg::POINT_W-1:0]    point_x,
    input  logic signed [rpcp_pkg::POINT_W-1:0]    point_y,
    input  logic signed [rpcp_pkg::POINT_W-1:0]    point_z,
    input  logic                                   end_of_line,
    input  logic [rpcp_pkg::ROW_W-1:0]             row0,
    input  logic [rpcp_pkg::ROW_W-1:0]             row1,
    input  logic [rpcp_pkg::ROW_W-1:0]             row2,
    input  logic                                   show_hidden,
    input  logic [rpcp_pkg::QCNT_W-1:0]            queue_count,
    output logic                                   push,
    output rpcp_pkg::rot_item_t                    push_item
);

    logic signed [rpcp_pkg::POINT_W-1:0] pt [3];
    logic [rpcp_pkg::ROW_W-1:0]          row [3];
    logic signed [rpcp_pkg::COEF_W-1:0]  coef [9];
    logic signed [rpcp_pkg::PROD_W-1:0]  prod_next [9];
    logic signed [rpcp_pkg::PROD_W-1:0]  prod_reg [9];
    logic signed [rpcp_pkg::ROT_W-1:0]   rot_sum [3];
    logic                                f1_valid_reg, f1_valid_next;
    logic                                f2_valid_reg, f2_valid_next;
    logic                                f1_eol_reg;
    rpcp_pkg::rot_item_t                 item_reg, item_next;
    logic [rpcp_pkg::QCNT_W:0]           credit;
    logic                                accept;

    assign pt[0]  = point_x;
    assign pt[1]  = point_y;
    assign pt[2]  = point_z;
    assign row[0] = row0;
    assign row[1] = row1;
    assign row[2] = row2;

    // One multiplier per matrix coefficient
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            assign coef[r*3+c]      = row[r][c*rpcp_pkg::COEF_W +: rpcp_pkg::COEF_W];
            assign prod_next[r*3+c] = coef[r*3+c] * pt[c];
        end
        assign rot_sum[r] = rpcp_pkg::ROT_W'(prod_reg[r*3])
                          + rpcp_pkg::ROT_W'(prod_reg[r*3+1])
                          + rpcp_pkg::ROT_W'(prod_reg[r*3+2]);
    end

    // Admit a request only when the queue has room for everything in flight
    assign credit = {1'b0, queue_count}
                  + (rpcp_pkg::QCNT_W+1)'(f1_valid_reg)
                  + (rpcp_pkg::QCNT_W+1)'(f2_valid_reg);
    assign in_ready = (credit < (rpcp_pkg::QCNT_W+1)'(rpcp_pkg::QUEUE_DEPTH));
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        f1_valid_next  = accept;
        f2_valid_next  = f1_valid_reg;
        item_next.rx   = rot_sum[0];
        item_next.ry   = rot_sum[1];
        item_next.proj = rot_sum[2][rpcp_pkg::ROT_W-1] | show_hidden;
        item_next.zero = (rot_sum[2] == '0);
        item_next.eol  = f1_eol_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg   <= prod_next;
            f1_eol_reg <= end_of_line;
        end
        if (f1_valid_reg)
        begin
            item_reg <= item_next;
        end
    end

    assign push      = f2_valid_reg;
    assign push_item = item_reg;

endmodule

// ===== sv/rpcp_queue.sv =====
`timescale 1ns / 1ps
// Small FIFO between the rotate front end and the project back end.
module rpcp_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  rpcp_pkg::rot_item_t             push_item,
    input  logic                            pop,
    output logic                            head_valid,
    output rpcp_pkg::rot_item_t             head_item,
    output logic [rpcp_pkg::QCNT_W-1:0]     count
);

    rpcp_pkg::rot_item_t             mem_reg [rpcp_pkg::QUEUE_DEPTH];
    logic [rpcp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rpcp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rpcp_pkg::QCNT_W-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != rpcp_pkg::QCNT_W'(rpcp_pkg::QUEUE_DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone push");
`endif

endmodule

// ===== sv/rpcp_back.sv =====
`timescale 1ns / 1ps
// Back end: zoom, pan, screen clip, break markers and the result register.
module rpcp_back #(
    parameter int SCREEN_LIMIT = 32000
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    input  rpcp_pkg::rot_item_t               head_item,
    output logic                              pop,
    input  rpcp_pkg::proj_cfg_t               cfg,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [rpcp_pkg::PIX_W-1:0] screen_x,
    output logic signed [rpcp_pkg::PIX_W-1:0] screen_y,
    output rpcp_pkg::point_kind_t             point_kind,
    output logic                              line_done
);

    localparam logic signed [rpcp_pkg::ACC_W-1:0] LIMIT_FIX =
        rpcp_pkg::ACC_W'(SCREEN_LIMIT) << rpcp_pkg::FRAC_SHIFT;

    logic                                   b1_valid_reg, b1_valid_next;
    logic signed [rpcp_pkg::SCALED_W-1:0]   b1_sx_reg, b1_sy_reg;
    logic signed [rpcp_pkg::SCALED_W-1:0]   sx_prod, sy_prod;
    logic                                   b1_proj_reg, b1_zero_reg, b1_eol_reg;
    logic                                   out_valid_reg, out_valid_next;
    logic signed [rpcp_pkg::PIX_W-1:0]      sx_reg, sx_next, sy_reg, sy_next;
    rpcp_pkg::point_kind_t                  kind_reg, kind_next;
    logic                                   eol_reg;
    logic                                   front_seen_reg, front_seen_next;
    logic signed [rpcp_pkg::ACC_W-1:0]      cx, cy;
    logic signed [rpcp_pkg::PIX_W-1:0]      tx, ty;
    logic                                   in_x, in_y;
    logic                                   out_adv, b1_en, out_load;

    assign out_adv  = !out_valid_reg || out_ready;
    assign b1_en    = !b1_valid_reg || out_adv;
    assign pop      = head_valid && b1_en;
    assign out_load = b1_valid_reg && out_adv;

    assign sx_prod = $signed({1'b0, cfg.zoom}) * head_item.rx;
    assign sy_prod = $signed({1'b0, cfg.zoom}) * head_item.ry;

    // Pan sits at the same binary point as the scaled coordinate
    assign cx = rpcp_pkg::ACC_W'(b1_sx_reg)
              + rpcp_pkg::ACC_W'($signed({cfg.pan_x, {rpcp_pkg::FRAC_SHIFT{1'b0}}}));
    assign cy = rpcp_pkg::ACC_W'(b1_sy_reg)
              + rpcp_pkg::ACC_W'($signed({cfg.pan_y, {rpcp_pkg::FRAC_SHIFT{1'b0}}}));

    assign in_x = (cx > -LIMIT_FIX) && (cx < LIMIT_FIX);
    assign in_y = (cy > -LIMIT_FIX) && (cy < LIMIT_FIX);

    // Truncate toward zero: bump negative values that have a fraction
    assign tx = cx[rpcp_pkg::FRAC_SHIFT +: rpcp_pkg::PIX_W]
              + rpcp_pkg::PIX_W'(cx[rpcp_pkg::ACC_W-1]
                                 && (cx[rpcp_pkg::FRAC_SHIFT-1:0] != '0));
    assign ty = cy[rpcp_pkg::FRAC_SHIFT +: rpcp_pkg::PIX_W]
              + rpcp_pkg::PIX_W'(cy[rpcp_pkg::ACC_W-1]
                                 && (cy[rpcp_pkg::FRAC_SHIFT-1:0] != '0));

    always_comb
    begin
        kind_next       = rpcp_pkg::KIND_NONE;
        sx_next         = '0;
        sy_next         = '0;
        front_seen_next = front_seen_reg;
        if (b1_proj_reg)
        begin
            if (in_x && in_y)
            begin
                kind_next = rpcp_pkg::KIND_POINT;
                sx_next   = tx;
                sy_next   = ty;
            end
            front_seen_next = 1'b1;
        end
        else if (b1_zero_reg || front_seen_reg)
        begin
            kind_next = rpcp_pkg::KIND_BREAK;
        end
        if (b1_eol_reg)
        begin
            front_seen_next = 1'b0;
        end
    end

    always_comb
    begin
        b1_valid_next  = b1_en ? head_valid : b1_valid_reg;
        out_valid_next = out_adv ? b1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            front_seen_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                front_seen_reg <= front_seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_sx_reg   <= sx_prod;
            b1_sy_reg   <= sy_prod;
            b1_proj_reg <= head_item.proj;
            b1_zero_reg <= head_item.zero;
            b1_eol_reg  <= head_item.eol;
        end
        if (out_load)
        begin
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            kind_reg <= kind_next;
            eol_reg  <= b1_eol_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign screen_x   = sx_reg;
    assign screen_y   = sy_reg;
    assign point_kind = kind_reg;
    assign line_done  = eol_reg;

endmodule

// ===== sv/rotate_project_clip_points.sv =====
`timescale 1ns / 1ps
// Top level of the point rotate, project and clip pipeline with its register bank.
//
// Each request on the slave side carries one polyline point in signed Q2.14 and
// returns exactly one result on the master side, in order. The front end
// multiplies the point by the configured 3x3 matrix (nine 18x16 multipliers,
// then a registered three-term sum per row) and tags it as projected, on the
// z plane, or hidden. A four-entry queue separates it from the back end, which
// scales by zoom (one 17x36 multiplier per axis), adds pan, clips against
// SCREEN_LIMIT on the exact fixed-point value, truncates toward zero, and
// tracks whether the current polyline has had a projected point so hidden
// points become break markers. The sustained rate is one point per cycle while
// the master side takes every result. A request taken on the slave side passes
// through the product, row sum, queue entry, zoom product and result registers
// in that order before its result is valid on the master side. The slave side
// holds off while the queue plus the two front stages would exceed four
// entries, so a stalled master side backs up into the queue before tready
// drops. Write configuration only while the pipeline is empty.
module rotate_project_clip_points #(
    parameter int SCREEN_LIMIT = 32000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // point_x [15:0], point_y [31:16], point_z [47:32]
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // screen_x [15:0], screen_y [31:16]
    output logic [1:0]  m_tuser,   // point_kind [1:0]
    output logic        m_tlast,   // line_done
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [53:0] cfg_data
);

    logic [rpcp_pkg::ROW_W-1:0]          row0_reg, row1_reg, row2_reg;
    logic [rpcp_pkg::ZOOM_W-1:0]         zoom_reg;
    logic signed [rpcp_pkg::PAN_W-1:0]   pan_x_reg, pan_y_reg;
    logic                                show_hidden_reg;
    rpcp_pkg::proj_cfg_t                 proj_cfg;

    logic                                push, pop, head_valid;
    rpcp_pkg::rot_item_t                 push_item, head_item;
    logic [rpcp_pkg::QCNT_W-1:0]         queue_count;
    logic signed [rpcp_pkg::PIX_W-1:0]   screen_x, screen_y;
    rpcp_pkg::point_kind_t               point_kind;

    // Register bank: writes to the unused index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg        <= rpcp_pkg::ROW0_RESET;
            row1_reg        <= rpcp_pkg::ROW1_RESET;
            row2_reg        <= rpcp_pkg::ROW2_RESET;
            zoom_reg        <= rpcp_pkg::ZOOM_RESET;
            pan_x_reg       <= '0;
            pan_y_reg       <= '0;
            show_hidden_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (rpcp_pkg::cfg_reg_t'(cfg_index))
                rpcp_pkg::REG_MATRIX_ROW0: row0_reg        <= cfg_data;
                rpcp_pkg::REG_MATRIX_ROW1: row1_reg        <= cfg_data;
                rpcp_pkg::REG_MATRIX_ROW2: row2_reg        <= cfg_data;
                rpcp_pkg::REG_ZOOM_SCALE:  zoom_reg        <= cfg_data[rpcp_pkg::ZOOM_W-1:0];
                rpcp_pkg::REG_PAN_X:       pan_x_reg       <= cfg_data[rpcp_pkg::PAN_W-1:0];
                rpcp_pkg::REG_PAN_Y:       pan_y_reg       <= cfg_data[rpcp_pkg::PAN_W-1:0];
                rpcp_pkg::REG_SHOW_HIDDEN: show_hidden_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign proj_cfg.zoom  = zoom_reg;
    assign proj_cfg.pan_x = pan_x_reg;
    assign proj_cfg.pan_y = pan_y_reg;

    // Rotate and classify
    rpcp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .point_x     (s_tdata[15:0]),
        .point_y     (s_tdata[31:16]),
        .point_z     (s_tdata[47:32]),
        .end_of_line (s_tlast),
        .row0        (row0_reg),
        .row1        (row1_reg),
        .row2        (row2_reg),
        .show_hidden (show_hidden_reg),
        .queue_count (queue_count),
        .push        (push),
        .push_item   (push_item)
    );

    // Decouple the two halves
    rpcp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .count      (queue_count)
    );

    // Project, clip and emit
    rpcp_back #(
        .SCREEN_LIMIT (SCREEN_LIMIT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .cfg        (proj_cfg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .point_kind (point_kind),
        .line_done  (m_tlast)
    );

    assign m_tdata = {screen_y, screen_x};
    assign m_tuser = point_kind;

endmodule
